### rtl/fixed_point_pid_step_top_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef FIXED_POINT_PID_STEP_TOP_MACROS_SVH
`define FIXED_POINT_PID_STEP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define FPPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FPPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPPS_ASSERT_IMP(lbl, ante, cons, msg)
`define FPPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/fpps_pkg.sv
`default_nettype none
package fpps_pkg;

  // Field widths
  localparam int ERR_W  = 16;
  localparam int STEP_W = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 31;
  localparam int DRV_W  = 32;
  localparam int INT_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_D_EN   = 3'd4;

  // Scaling shifts (truncating toward zero on signed values)
  localparam logic [3:0] P_SHIFT   = 4'd6;   // kP / 64
  localparam logic [3:0] INT_SHIFT = 4'd11;  // trapezoid / 2048
  localparam logic [3:0] I_SHIFT   = 4'd13;  // kI / 8192
  localparam logic [3:0] D_SHIFT   = 4'd2;   // kD / 4
  localparam int         Q_SHIFT   = 6;      // derivative quotient / 64
  localparam int         AVG_SHIFT = 5;      // (dt + last_dt) / 2 / 16
  localparam logic [STEP_W-1:0] D_SCALE = 16'hFFFF;

  // Shared multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = 50;

  // Serial divider
  localparam int DVD_W = 32;
  localparam int DVS_W = STEP_W + 1 - AVG_SHIFT;
  localparam int CNT_W = $clog2(DVD_W + 1);

  // Intermediate term widths
  localparam int P_W = 26;
  localparam int X_W = DVD_W - Q_SHIFT + 1;
  localparam int D_W = 42;
  localparam int S_W = D_W + 1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/fpps_if.sv
`default_nettype none
interface fpps_in_if;
  import fpps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ERR_W-1:0]  error_in;
  logic        [STEP_W-1:0] step_time;
  logic                     clear;
  modport source (output valid, error_in, step_time, clear, input ready);
  modport sink (input valid, error_in, step_time, clear, output ready);
endinterface

interface fpps_out_if;
  import fpps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface fpps_cfg_if;
  import fpps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/fpps_mul.sv
`default_nettype none
module fpps_mul (
  input  logic                                 clk,
  input  logic signed [fpps_pkg::MUL_A_W-1:0]  a,
  input  logic signed [fpps_pkg::MUL_B_W-1:0]  b,
  output logic signed [fpps_pkg::MUL_P_W-1:0]  p
);
  import fpps_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
`default_nettype wire

### rtl/fpps_div.sv
`default_nettype none
`include "fixed_point_pid_step_top_macros.svh"
module fpps_div (
  input  logic                         clk,
  input  logic                         rst,
  input  fpps_pkg::div_req_t           req,
  output fpps_pkg::div_stat_t          stat,
  output logic [fpps_pkg::DVD_W-1:0]   quotient
);
  import fpps_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] quo;
  logic [DVD_W-1:0] quo_next;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  // One restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    trial   = shifted - {1'b0, dvs};
    if (!trial[DVS_W]) begin
      rem_next = trial[DVS_W-1:0];
      quo_next = {quo[DVD_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[DVS_W-1:0];
      quo_next = {quo[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && cnt == '0) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = quo;

  `FPPS_ASSERT_IMP(a_done_idle, done, cnt == '0, "divider done while still iterating")
  `FPPS_ASSERT_NXT(a_start_busy, req.start && cnt == '0, cnt != '0, "divider start lost")
  `FPPS_ASSERT_IMP(a_rem_bound, cnt != '0 && dvs != '0, rem < dvs, "partial remainder overflow")

endmodule
`default_nettype wire

### rtl/fixed_point_pid_step_top.sv
// Fixed-point PID step with trapezoidal integral.
// Channels: sample (error_in, step_time, clear) in, result (drive) out, and
// cfg, a register write port that is always ready; write registers only while
// the block is idle. All channels transfer on valid && ready.
// Each accepted sample produces exactly one drive value. The block handles one
// sample at a time: sample.ready is high only while the sequencer is idle.
// Steps after a sample transfers: a clear goes straight to S_SUM; a zero
// step_time runs S_P and S_I1; with no derivative S_P, S_I1 to S_I4 run; with
// the derivative division S_D1 to S_D5 follow, waiting in S_D3 for the
// divider. All end in S_SUM, which writes the result and returns to idle.
// The derivative path runs a one-bit-per-cycle divider on a 32-bit dividend;
// all products go through one shared, registered 33x17 multiplier.
// The result sits in an output register, so a new sample is accepted while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in its final step until the register frees up.
// Reset clears the integral, the error and step history, and the gains and
// limit; derivative_enable resets to 1 (PID mode with output clamp).
`default_nettype none
`include "fixed_point_pid_step_top_macros.svh"
module fixed_point_pid_step_top (
  input  logic        clk,
  input  logic        rst,
  fpps_in_if.sink     sample,
  fpps_out_if.source  result,
  fpps_cfg_if.sink    cfg
);
  import fpps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_P    = 12'b0000_0000_0010,
    S_I1   = 12'b0000_0000_0100,
    S_I2   = 12'b0000_0000_1000,
    S_I3   = 12'b0000_0001_0000,
    S_I4   = 12'b0000_0010_0000,
    S_D1   = 12'b0000_0100_0000,
    S_D2   = 12'b0000_1000_0000,
    S_D3   = 12'b0001_0000_0000,
    S_D4   = 12'b0010_0000_0000,
    S_D5   = 12'b0100_0000_0000,
    S_SUM  = 12'b1000_0000_0000
  } state_t;

  function automatic logic signed [MUL_P_W-1:0] trunc_shr(
    input logic signed [MUL_P_W-1:0] v,
    input logic [3:0]                k
  );
    logic signed [MUL_P_W-1:0] bias;
    bias = v[MUL_P_W-1] ? ((MUL_P_W'(1) << k) - MUL_P_W'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

  state_t state;

  // Configuration
  logic [GAIN_W-1:0] p_gain;
  logic [GAIN_W-1:0] i_gain;
  logic [GAIN_W-1:0] d_gain;
  logic [LIM_W-1:0]  lim;
  logic              den;

  // Controller state
  logic signed [INT_W-1:0] integral;
  logic signed [ERR_W-1:0] last_error;
  logic [STEP_W-1:0]       last_step;

  // Working registers
  logic signed [ERR_W-1:0] e_reg;
  logic [STEP_W-1:0]       dt_reg;
  logic                    clr_reg;
  logic signed [P_W-1:0]   p_term;
  logic signed [INT_W-1:0] i_term;
  logic signed [D_W-1:0]   d_term;
  logic [DVS_W-1:0]        q_reg;
  logic                    neg_d;
  logic signed [X_W-1:0]   x_reg;
  logic signed [DRV_W-1:0] drive_reg;
  logic                    out_valid;

  // Datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [3:0]                shr_k;
  logic signed [MUL_P_W-1:0] prod_shr;
  logic signed [ERR_W:0]     err_sum;
  logic signed [ERR_W:0]     diff;
  logic [ERR_W:0]            diff_mag;
  logic [STEP_W:0]           step_sum;
  logic [DVS_W-1:0]          q;
  logic signed [INT_W+1:0]   int_acc;
  logic signed [INT_W-1:0]   int_sat;
  logic signed [MUL_P_W-1:0] lim_w;
  logic signed [INT_W-1:0]   i_clamp;
  logic [DVD_W-Q_SHIFT-1:0]  quot_sh;
  logic signed [S_W-1:0]     pid_sum;
  logic signed [S_W-1:0]     lim_s;
  logic signed [DRV_W:0]     pi_sum;
  logic signed [DRV_W-1:0]   drive_next;
  logic signed [DRV_W:0]     lim_ext;
  logic                      out_free;
  logic                      in_xfer;

  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quo;

  fpps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fpps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_xfer  = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  assign err_sum  = (ERR_W+1)'(e_reg) + (ERR_W+1)'(last_error);
  assign diff     = (ERR_W+1)'(e_reg) - (ERR_W+1)'(last_error);
  assign diff_mag = diff[ERR_W] ? $unsigned(-diff) : $unsigned(diff);
  assign step_sum = {1'b0, dt_reg} + {1'b0, last_step};
  assign q        = step_sum[STEP_W:AVG_SHIFT];

  // Operand select for the shared multiplier; product is read in the next state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P: begin
        mul_a = MUL_A_W'(e_reg);
        mul_b = $signed({1'b0, p_gain});
      end
      S_I1: begin
        mul_a = MUL_A_W'(err_sum);
        mul_b = $signed({1'b0, dt_reg});
      end
      S_I3: begin
        mul_a = MUL_A_W'(integral);
        mul_b = $signed({1'b0, i_gain});
      end
      S_D1: begin
        mul_a = $signed({{(MUL_A_W-ERR_W-1){1'b0}}, diff_mag});
        mul_b = $signed({1'b0, D_SCALE});
      end
      S_D4: begin
        mul_a = MUL_A_W'(x_reg);
        mul_b = $signed({1'b0, d_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_I1:    shr_k = P_SHIFT;
      S_I2:    shr_k = INT_SHIFT;
      S_I4:    shr_k = I_SHIFT;
      S_D5:    shr_k = D_SHIFT;
      default: shr_k = '0;
    endcase
  end

  assign prod_shr = trunc_shr(mul_p, shr_k);

  // Integral update with 32-bit saturation
  always_comb begin
    int_acc = (INT_W+2)'(integral) + (INT_W+2)'(prod_shr);
    if (int_acc[INT_W+1:INT_W-1] == 3'b000 || int_acc[INT_W+1:INT_W-1] == 3'b111) begin
      int_sat = int_acc[INT_W-1:0];
    end else if (int_acc[INT_W+1]) begin
      int_sat = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      int_sat = {1'b0, {(INT_W-1){1'b1}}};
    end
  end

  // Clamp I to +-limit
  always_comb begin
    lim_w = $signed({{(MUL_P_W-LIM_W){1'b0}}, lim});
    if (prod_shr > lim_w) begin
      i_clamp = INT_W'(lim_w);
    end else if (prod_shr < -lim_w) begin
      i_clamp = INT_W'(-lim_w);
    end else begin
      i_clamp = prod_shr[INT_W-1:0];
    end
  end

  assign quot_sh = div_quo[DVD_W-1:Q_SHIFT];

  // Final sum: clamp in PID mode, saturate in PI mode
  always_comb begin
    pid_sum = S_W'(p_term) + S_W'(i_term) + S_W'(d_term);
    lim_s   = $signed({{(S_W-LIM_W){1'b0}}, lim});
    pi_sum  = (DRV_W+1)'(p_term) + (DRV_W+1)'(i_term);
    if (den) begin
      if (pid_sum > lim_s) begin
        drive_next = DRV_W'(lim_s);
      end else if (pid_sum < -lim_s) begin
        drive_next = DRV_W'(-lim_s);
      end else begin
        drive_next = pid_sum[DRV_W-1:0];
      end
    end else begin
      if (pi_sum[DRV_W] == pi_sum[DRV_W-1]) begin
        drive_next = pi_sum[DRV_W-1:0];
      end else if (pi_sum[DRV_W]) begin
        drive_next = {1'b1, {(DRV_W-1){1'b0}}};
      end else begin
        drive_next = {1'b0, {(DRV_W-1){1'b1}}};
      end
    end
  end

  assign div_req.start    = (state == S_D2);
  assign div_req.dividend = mul_p[DVD_W-1:0];
  assign div_req.divisor  = q_reg;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= '0;
      i_gain <= '0;
      d_gain <= '0;
      lim    <= '0;
      den    <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_P_GAIN: p_gain <= cfg.data[GAIN_W-1:0];
        CFG_I_GAIN: i_gain <= cfg.data[GAIN_W-1:0];
        CFG_D_GAIN: d_gain <= cfg.data[GAIN_W-1:0];
        CFG_LIMIT:  lim    <= cfg.data[LIM_W-1:0];
        CFG_D_EN:   den    <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      integral   <= '0;
      last_error <= '0;
      last_step  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            e_reg   <= sample.error_in;
            dt_reg  <= sample.step_time;
            clr_reg <= sample.clear;
            p_term  <= '0;
            i_term  <= '0;
            d_term  <= '0;
            if (sample.clear) begin
              integral   <= '0;
              last_error <= '0;
              last_step  <= '0;
              state      <= S_SUM;
            end else begin
              state <= S_P;
            end
          end
        end
        S_P: begin
          state <= S_I1;
        end
        S_I1: begin
          p_term <= prod_shr[P_W-1:0];
          state  <= (dt_reg == '0) ? S_SUM : S_I2;
        end
        S_I2: begin
          integral <= int_sat;
          state    <= S_I3;
        end
        S_I3: begin
          state <= S_I4;
        end
        S_I4: begin
          i_term <= i_clamp;
          q_reg  <= q;
          neg_d  <= diff[ERR_W];
          state  <= (last_step != '0 && q != '0) ? S_D1 : S_SUM;
        end
        S_D1: begin
          state <= S_D2;
        end
        S_D2: begin
          state <= S_D3;
        end
        S_D3: begin
          if (div_stat.done) begin
            x_reg <= neg_d ? -$signed({1'b0, quot_sh}) : $signed({1'b0, quot_sh});
            state <= S_D4;
          end
        end
        S_D4: begin
          state <= S_D5;
        end
        S_D5: begin
          d_term <= prod_shr[D_W-1:0];
          state  <= S_SUM;
        end
        S_SUM: begin
          // hold until the output register is free
          if (out_free) begin
            drive_reg <= drive_next;
            if (!clr_reg && dt_reg != '0) begin
              last_error <= e_reg;
              last_step  <= dt_reg;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.drive = drive_reg;
  assign cfg.ready    = 1'b1;

  assign lim_ext = $signed({{(DRV_W+1-LIM_W){1'b0}}, lim});

  `FPPS_ASSERT_IMP(a_div_nonzero, state == S_D2, q_reg != '0, "divider started with zero divisor")
  `FPPS_ASSERT_IMP(a_pid_clamp, out_valid && den,
    (DRV_W+1)'(drive_reg) <= lim_ext && (DRV_W+1)'(drive_reg) >= -lim_ext,
    "PID output outside limit")
  `FPPS_ASSERT_NXT(a_clear_state, in_xfer && sample.clear,
    integral == '0 && last_error == '0 && last_step == '0, "clear left state behind")

endmodule
`default_nettype wire

### tb/fixed_point_pid_step_top_tb.sv
`default_nettype none
module fixed_point_pid_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpps_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;

  class pid_tracker;
    int kp, ki, kd;
    longint limit;
    bit d_en;
    int integral;
    logic signed [ERR_W-1:0] last_err;
    int last_dt;
    logic signed [DRV_W-1:0] expected_drive[$];
    int mismatches;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      limit = 0;
      d_en = 1'b1;
      integral = 0;
      last_err = '0;
      last_dt = 0;
      mismatches = 0;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_P_GAIN: kp = data[GAIN_W-1:0];
        CFG_I_GAIN: ki = data[GAIN_W-1:0];
        CFG_D_GAIN: kd = data[GAIN_W-1:0];
        CFG_LIMIT:  limit = data[LIM_W-1:0];
        CFG_D_EN:   d_en = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [DRV_W-1:0] predict_drive(logic signed [ERR_W-1:0] err,
                                                    logic [STEP_W-1:0] dt, logic clr);
      longint e, prev, p, i_term, d_term, acc, x, total;
      int dt_i, q;
      if (clr) begin
        integral = 0;
        last_err = '0;
        last_dt = 0;
        return '0;
      end
      e = err;
      prev = last_err;
      dt_i = dt;
      i_term = 0;
      d_term = 0;
      p = sat32(e * kp / 64);
      if (dt_i != 0) begin
        acc = longint'(integral) + (e + prev) * dt_i / 2048;
        integral = int'(sat32(acc));
        i_term = clamp(longint'(integral) * ki / 8192, limit);
        // derivative uses the error from before this step
        if (last_dt != 0) begin
          q = ((dt_i + last_dt) / 2) / 16;
          if (q != 0) begin
            x = (e - prev) * longint'(D_SCALE);
            x = x / q / 64;
            d_term = x * kd / 4;
          end
        end
        last_err = err;
        last_dt = dt_i;
      end
      if (d_en) total = clamp(p + i_term + d_term, limit);
      else total = sat32(p + i_term);
      return total[DRV_W-1:0];
    endfunction

    function void note_sample(logic signed [ERR_W-1:0] err, logic [STEP_W-1:0] dt,
                              logic clr);
      expected_drive.push_back(predict_drive(err, dt, clr));
    endfunction

    function void check_drive(logic signed [DRV_W-1:0] actual);
      logic signed [DRV_W-1:0] want;
      if (expected_drive.size() == 0) begin
        $error("drive: no expected value, actual %0d", actual);
        mismatches++;
        return;
      end
      want = expected_drive.pop_front();
      if (actual !== want) begin
        $error("drive mismatch: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit no_idle = 1'b0;
  int hold_token = 0;
  int items_sent = 0;
  int cycle_count = 0;
  pid_tracker tracker = new();

  fpps_in_if  sample_ch ();
  fpps_out_if result_ch ();
  fpps_cfg_if cfg_ch ();

  fixed_point_pid_step_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.error_in = '0;
    sample_ch.step_time = '0;
    sample_ch.clear = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  // result side: random stalls, plus a long hold whenever the token moves
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) tracker.check_drive(result_ch.drive);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fixed_point_pid_step_top regression: fail");
    $finish;
  end

  task automatic send_sample(logic signed [ERR_W-1:0] err, logic [STEP_W-1:0] dt,
                             logic clr);
    int gap;
    sample_ch.valid <= 1'b1;
    sample_ch.error_in <= err;
    sample_ch.step_time <= dt;
    sample_ch.clear <= clr;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.note_sample(err, dt, clr);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 50 : 4);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // lower valid and let every outstanding result come back
  task automatic pause_sender();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  task automatic program_regs(int kp, int ki, int kd, int lim, bit den);
    logic [CFG_IDX_W-1:0] idx[5];
    logic [CFG_DAT_W-1:0] val[5];
    idx = '{CFG_P_GAIN, CFG_I_GAIN, CFG_D_GAIN, CFG_LIMIT, CFG_D_EN};
    val = '{kp, ki, kd, lim, {31'd0, den}};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
      tracker.write_reg(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int pick_gain();
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(4))
      0: return 0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1, 100000);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  // smoothly moving error with a step time drawn from one band, or zero
  task automatic run_track(int len);
    int e, dt, dt_lo, dt_hi, stepw;
    e = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(3))
      0: begin dt_lo = 1; dt_hi = 40; end
      1: begin dt_lo = 40; dt_hi = 2000; end
      2: begin dt_lo = 2000; dt_hi = 65535; end
      default: begin dt_lo = 0; dt_hi = 65535; end
    endcase
    stepw = $urandom_range(1) ? 300 : 8000;
    for (int k = 0; k < len; k++) begin
      e = e + int'($urandom_range(0, 2 * stepw)) - stepw;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      dt = ($urandom_range(9) == 0) ? 0 : $urandom_range(dt_lo, dt_hi);
      send_sample(e[ERR_W-1:0], dt[STEP_W-1:0], 1'b0);
    end
  endtask

  task automatic run_mixed(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2: send_sample(ERR_W'($urandom), STEP_W'($urandom), 1'b1);
        3, 4, 5: send_sample(ERR_W'($urandom), STEP_W'($urandom), $urandom_range(7) == 0);
        default: run_track($urandom_range(5, 20));
      endcase
    end
  endtask

  // drive the integral into saturation with large errors of one sign
  task automatic run_windup(bit negative, int len);
    int e;
    send_sample('0, '0, 1'b1);
    for (int k = 0; k < len; k++) begin
      e = $urandom_range(32700, 32767);
      if (negative) e = -e - 1;
      send_sample(e[ERR_W-1:0], STEP_W'($urandom_range(65000, 65535)), 1'b0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero gains and limit with the clamp on
    send_sample(16'sd1000, 16'd100, 1'b0);
    send_sample(-16'sd1000, 16'd100, 1'b0);
    pause_sender();

    program_regs(64, 8192, 4, 32'h7FFF_FFFF, 1'b1);
    send_sample('0, '0, 1'b1);
    send_sample(16'sd100, 16'd0, 1'b0);
    send_sample(16'sd100, 16'd32, 1'b0);
    send_sample(-16'sd200, 16'd32, 1'b0);
    send_sample(16'sd32767, 16'd65535, 1'b0);
    send_sample(-16'sd32768, 16'd65535, 1'b0);
    send_sample(16'sd32767, 16'd65535, 1'b0);
    send_sample(16'sd0, 16'd0, 1'b0);
    send_sample(16'sd5, 16'd1, 1'b0);
    send_sample('0, '0, 1'b1);
    send_sample(16'sd10, 16'd1, 1'b0);
    send_sample(16'sd20, 16'd1, 1'b0);
    send_sample(-16'sd32768, 16'd31, 1'b0);
    send_sample(16'sd32767, 16'd1, 1'b0);
    send_sample(16'sd1234, 16'd65535, 1'b1);
    send_sample(-16'sd1, 16'd65535, 1'b0);
    pause_sender();

    program_regs(65535, 65535, 65535, 1000, 1'b1);
    send_sample(16'sd32767, 16'd100, 1'b0);
    send_sample(-16'sd32768, 16'd100, 1'b0);
    send_sample(16'sd12345, 16'd0, 1'b0);
    pause_sender();

    program_regs(65535, 65535, 0, 0, 1'b0);
    send_sample(16'sd32767, 16'd200, 1'b0);
    send_sample(-16'sd32768, 16'd200, 1'b0);
    send_sample('0, '0, 1'b1);
    pause_sender();

    // integral and output saturation, no idling on either side
    no_idle <= 1'b1;
    program_regs(65535, 65535, $urandom_range(0, 65535), 32'h7FFF_FFFF, 1'b0);
    run_windup($urandom_range(1), 1045);
    pause_sender();
    no_idle <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(65535, 65535, 65535, 32'h7FFF_FFFF, 1'b1);
        1: program_regs(0, 0, 0, 0, 1'b0);
        default: program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                              $urandom_range(1));
      endcase
      if (ph == 4) begin
        // hold off the result side while samples keep coming
        hold_token <= hold_token + 1;
        run_mixed(20);
      end
      run_mixed(12);
      pause_sender();
    end

    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("fixed_point_pid_step_top regression: pass");
    end else begin
      $display("fixed_point_pid_step_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/fpps_pkg.sv
rtl/fpps_if.sv
rtl/fpps_mul.sv
rtl/fpps_div.sv
rtl/fixed_point_pid_step_top.sv
tb/fixed_point_pid_step_top_tb.sv
